@@ rtl/wstd_pkg.sv @@
`timescale 1ns / 1ps

package wstd_pkg;

   localparam int DEF_QUEUE_DEPTH = 64;
   localparam int DEF_MAX_WORKERS = 16;

   localparam int OP_W     = 2;
   localparam int WORKER_W = 4;
   localparam int TASK_W   = 16;
   localparam int QUSED_W  = 4;
   localparam int COUNT_W  = 10;
   localparam int WCOUNT_W = 5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [OP_W-1:0] OP_SUBMIT   = 2'd0;
   localparam logic [OP_W-1:0] OP_FETCH    = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPLETE = 2'd2;

   // request word, lowest bits first: worker, task_id, zero pad
   typedef struct packed {
      logic [3:0]          pad;
      logic [TASK_W-1:0]   task_id;
      logic [WORKER_W-1:0] worker;
   } req_word_type;

   // response word, lowest bits first: success, queue_used, task_out,
   // was_stolen, active_count
   typedef struct packed {
      logic [COUNT_W-1:0] active_count;
      logic               was_stolen;
      logic [TASK_W-1:0]  task_out;
      logic [QUSED_W-1:0] queue_used;
      logic               success;
   } rsp_word_type;

endpackage

@@ rtl/work_stealing_task_dispatcher.sv @@
`timescale 1ns / 1ps

// Work-stealing task dispatcher: one ring queue of task ids per worker plus an
// active-task count. A submit (op 0) pushes task_id to queue (count mod
// worker_count), moving on to later queues when full; a fetch (op 1) pops the
// worker's own queue or steals the oldest entry of the next non-empty one; a
// complete (op 2) lowers the count. Each request word gives one response word.
// Items are handled one at a time by a small sequencer around a subtract/compare
// unit for the remainder: a submit runs 10 restoring remainder steps for the
// target queue, probes up to worker_count queues and posts the response; a fetch
// probes up to worker_count queues, or goes straight to the response when the
// worker is outside the live queues; a complete or the unused op goes straight
// to the response. Posting the response waits while the previous response word
// is still unaccepted. The queue probe loop visits one queue per cycle and the
// task memory is read at most once per fetch with registered data. A new request
// is taken as soon as the sequencer is back in idle, even while the previous
// response waits. Configuration (csr_we / csr_wdata) may be written only while
// the block is idle.

module work_stealing_task_dispatcher
   import wstd_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int MAX_WORKERS = DEF_MAX_WORKERS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,  // worker[3:0], task_id[19:4], pad
   input  logic [OP_W-1:0]     req_tuser,  // op[1:0]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,  // success, queue_used, task_out,
                                           // was_stolen, active_count
   input  logic                csr_we,
   input  logic [WCOUNT_W-1:0] csr_wdata
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QW    = $clog2(MAX_WORKERS);
   localparam int NW    = $clog2(MAX_WORKERS + 1);
   localparam int CMP_W = NW + WORKER_W;
   localparam int MEM_D = MAX_WORKERS * QUEUE_DEPTH;
   localparam int AW    = $clog2(MEM_D);
   localparam int STEP_W = $clog2(COUNT_W);

   localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(COUNT_W - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MOD  = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   req_word_type req_word;
   rsp_word_type rsp_word_in;
   rsp_word_type rsp_word_ff;

   logic [1:0]          state_ff, state_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [TASK_W-1:0]   id_ff, id_in;
   logic [COUNT_W-1:0]  div_ff, div_in;
   logic [NW-1:0]       rem_ff, rem_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [QW-1:0]       q_ff, q_in;
   logic [NW-1:0]       i_ff, i_in;
   logic                ok_ff, ok_in;
   logic                stolen_ff, stolen_in;
   logic [QW-1:0]       qused_ff, qused_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [WCOUNT_W-1:0] wcount_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [TASK_W-1:0]   rd_data_ff;

   logic [PTR_W-1:0] wp_ff [MAX_WORKERS];
   logic [PTR_W-1:0] rp_ff [MAX_WORKERS];
   logic [TASK_W-1:0] task_mem [MEM_D];

   logic [NW-1:0]    live_n;
   logic [NW-1:0]    n_last;
   logic [CMP_W-1:0] w_ext;
   logic [CMP_W-1:0] qused_ext;
   logic [NW:0]      alu_a, alu_b, alu_diff;
   logic             alu_ge;
   logic [PTR_W-1:0] wp_cur, rp_cur, wp_inc, rp_inc;
   logic             q_full, q_empty, scan_last;
   logic [QW-1:0]    q_wrap;
   logic             mem_we, mem_re, wp_we, rp_we;
   logic [AW-1:0]    mem_addr;
   logic             out_free;

   assign req_word = req_tdata;

   always_comb begin
      if (wcount_ff == '0) begin
         live_n = NW'(1);
      end else if (32'(wcount_ff) > MAX_WORKERS) begin
         live_n = NW'(MAX_WORKERS);
      end else begin
         live_n = NW'(wcount_ff);
      end
   end

   assign n_last    = live_n - NW'(1);
   assign w_ext     = CMP_W'(req_word.worker);
   assign qused_ext = CMP_W'(qused_ff);

   // subtract/compare unit: remainder steps
   assign alu_a    = {rem_ff, div_ff[COUNT_W-1]};
   assign alu_b    = {1'b0, live_n};
   assign alu_diff = alu_a - alu_b;
   assign alu_ge   = (alu_a >= alu_b);

   assign wp_cur    = wp_ff[q_ff];
   assign rp_cur    = rp_ff[q_ff];
   assign wp_inc    = (wp_cur == PTR_LAST) ? '0 : wp_cur + PTR_W'(1);
   assign rp_inc    = (rp_cur == PTR_LAST) ? '0 : rp_cur + PTR_W'(1);
   assign q_full    = (wp_inc == rp_cur);
   assign q_empty   = (wp_cur == rp_cur);
   assign scan_last = (i_ff == n_last);
   assign q_wrap    = (NW'(q_ff) == n_last) ? '0 : q_ff + QW'(1);

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign mem_addr  = AW'(q_ff) * AW'(QUEUE_DEPTH) + AW'(mem_we ? wp_cur : rp_cur);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      q_in         = q_ff;
      i_in         = i_ff;
      ok_in        = ok_ff;
      stolen_in    = stolen_ff;
      qused_in     = qused_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      wp_we        = 1'b0;
      rp_we        = 1'b0;
      rsp_word_in  = rsp_word_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tuser;
               id_in     = req_word.task_id;
               ok_in     = 1'b0;
               stolen_in = 1'b0;
               qused_in  = '0;
               state_in  = ST_OUT;
               case (req_tuser)
                  OP_SUBMIT: begin
                     div_in   = count_ff;
                     rem_in   = '0;
                     step_in  = '0;
                     state_in = ST_MOD;
                  end
                  OP_FETCH: begin
                     if (w_ext < CMP_W'(live_n)) begin
                        q_in     = QW'(w_ext);
                        i_in     = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  OP_COMPLETE: begin
                     if (count_ff != '0) begin
                        count_in = count_ff - COUNT_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MOD: begin
            rem_in  = alu_ge ? alu_diff[NW-1:0] : alu_a[NW-1:0];
            div_in  = div_ff << 1;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               q_in     = QW'(rem_in);
               i_in     = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (op_ff == OP_SUBMIT) begin
               if (!q_full) begin
                  mem_we   = 1'b1;
                  wp_we    = 1'b1;
                  ok_in    = 1'b1;
                  qused_in = q_ff;
                  if (count_ff != COUNT_MAX) begin
                     count_in = count_ff + COUNT_W'(1);
                  end
                  state_in = ST_OUT;
               end else if (scan_last) begin
                  state_in = ST_OUT;
               end else begin
                  q_in = q_wrap;
                  i_in = i_ff + NW'(1);
               end
            end else begin
               if (!q_empty) begin
                  mem_re    = 1'b1;
                  rp_we     = 1'b1;
                  ok_in     = 1'b1;
                  qused_in  = q_ff;
                  stolen_in = (i_ff != '0);
                  state_in  = ST_OUT;
               end else if (scan_last) begin
                  state_in = ST_OUT;
               end else begin
                  q_in = q_wrap;
                  i_in = i_ff + NW'(1);
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_word_in.success      = ok_ff;
               rsp_word_in.queue_used   = qused_ext[QUSED_W-1:0];
               rsp_word_in.task_out     = (ok_ff && op_ff == OP_FETCH) ? rd_data_ff : '0;
               rsp_word_in.was_stolen   = stolen_ff;
               rsp_word_in.active_count = count_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         wcount_ff    <= WCOUNT_W'(16);
         rsp_valid_ff <= 1'b0;
         ok_ff        <= 1'b0;
         stolen_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         ok_ff        <= ok_in;
         stolen_ff    <= stolen_in;
         if (csr_we) begin
            wcount_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      id_ff       <= id_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      q_ff        <= q_in;
      i_ff        <= i_in;
      qused_ff    <= qused_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_WORKERS; k++) begin
            wp_ff[k] <= '0;
            rp_ff[k] <= '0;
         end
      end else begin
         if (wp_we) begin
            wp_ff[q_ff] <= wp_inc;
         end
         if (rp_we) begin
            rp_ff[q_ff] <= rp_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         task_mem[mem_addr] <= id_ff;
      end
      if (mem_re) begin
         rd_data_ff <= task_mem[mem_addr];
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff != ST_IDLE)
      else $error("sequencer idle right after accepting a word");

   a_scan_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> (i_ff < live_n) && (NW'(q_ff) < live_n))
      else $error("queue probe outside the live queues");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_word_ff.success |->
         rsp_word_ff.queue_used == '0 && !rsp_word_ff.was_stolen &&
         rsp_word_ff.task_out == '0)
      else $error("failed response carries payload");

   a_stolen_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.was_stolen |-> rsp_word_ff.success)
      else $error("steal reported without success");

   a_single_mem_op: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("task memory read and written in one cycle");
`endif

endmodule

@@ tb/work_stealing_task_dispatcher_tb.sv @@
`timescale 1ns / 1ps

module work_stealing_task_dispatcher_tb;
   import wstd_pkg::*;

   localparam int PTR_W = $clog2(DEF_QUEUE_DEPTH);
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [23:0]         req_tdata;
   logic [OP_W-1:0]     req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [31:0]         rsp_tdata;
   logic                csr_we;
   logic [WCOUNT_W-1:0] csr_wdata;

   work_stealing_task_dispatcher u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // queue model
   logic [PTR_W-1:0]    tail_ptr [DEF_MAX_WORKERS] = '{default: '0};
   logic [PTR_W-1:0]    head_ptr [DEF_MAX_WORKERS] = '{default: '0};
   logic [TASK_W-1:0]   id_store [DEF_MAX_WORKERS][DEF_QUEUE_DEPTH];
   logic [COUNT_W-1:0]  live_count = '0;
   logic [WCOUNT_W-1:0] wcount_reg = 5'd16;

   rsp_word_type pending_rsp[$];
   int error_count = 0;
   int cycle_count = 0;
   int rsp_hold_req = 0;
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int active_queues(input logic [WCOUNT_W-1:0] wc);
      if (wc == 0) return 1;
      if (wc > DEF_MAX_WORKERS) return DEF_MAX_WORKERS;
      return int'(wc);
   endfunction

   function automatic logic [WORKER_W-1:0] rand_worker();
      return WORKER_W'($urandom_range(0, 15));
   endfunction

   function automatic logic [TASK_W-1:0] rand_task();
      return TASK_W'($urandom_range(0, 16'hFFFF));
   endfunction

   function automatic rsp_word_type dispatch_predict(input logic [OP_W-1:0] op,
                                                     input logic [WORKER_W-1:0] wkr,
                                                     input logic [TASK_W-1:0] id);
      rsp_word_type r;
      int n;
      int q;
      int target;
      bit done;
      logic [PTR_W-1:0] nxt;
      r = '0;
      done = 1'b0;
      n = active_queues(wcount_reg);
      case (op)
         OP_SUBMIT: begin
            target = live_count % n;
            for (int i = 0; i < n && !done; i++) begin
               q = (target + i) % n;
               nxt = tail_ptr[q] + 1'b1;
               if (nxt != head_ptr[q]) begin
                  id_store[q][tail_ptr[q]] = id;
                  tail_ptr[q] = nxt;
                  if (live_count != COUNT_MAX) live_count = live_count + 1'b1;
                  r.success = 1'b1;
                  r.queue_used = QUSED_W'(q);
                  done = 1'b1;
               end
            end
         end
         OP_FETCH: begin
            if (wkr < n) begin
               for (int i = 0; i < n && !done; i++) begin
                  q = (wkr + i) % n;
                  if (tail_ptr[q] != head_ptr[q]) begin
                     r.task_out = id_store[q][head_ptr[q]];
                     head_ptr[q] = head_ptr[q] + 1'b1;
                     r.success = 1'b1;
                     r.queue_used = QUSED_W'(q);
                     r.was_stolen = (i != 0);
                     done = 1'b1;
                  end
               end
            end
         end
         OP_COMPLETE: begin
            if (live_count != 0) live_count = live_count - 1'b1;
         end
         default: ;
      endcase
      r.active_count = live_count;
      return r;
   endfunction

   task automatic send_word(input logic [OP_W-1:0] op, input logic [WORKER_W-1:0] wkr,
                            input logic [TASK_W-1:0] id);
      int gap;
      req_word_type w;
      gap = req_idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      w = '0;
      w.worker = wkr;
      w.task_id = id;
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tuser  <= op;
      do @(posedge clock); while (req_tready !== 1'b1);
      pending_rsp.push_back(dispatch_predict(op, wkr, id));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_workers(input logic [WCOUNT_W-1:0] wc);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= wc;
      @(posedge clock);
      wcount_reg = wc;
      csr_we <= 1'b0;
   endtask

   // response sink
   initial begin : rsp_sink
      int stall;
      int hold;
      forever begin
         if (rsp_hold_req > 0) begin
            hold = rsp_hold_req;
            rsp_hold_req = 0;
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         stall = rsp_idle_on ? $urandom_range(0, 11) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid === 1'b1 && rsp_tready === 1'b1));
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_word_type got;
      rsp_word_type want;
      if (reset === 1'b0 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got = rsp_word_type'(rsp_tdata);
         if (pending_rsp.size() == 0) begin
            $error("response word with no request pending: %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.success !== want.success) begin
               $error("success: expected %0d, got %0d", want.success, got.success);
               error_count++;
            end
            if (got.queue_used !== want.queue_used) begin
               $error("queue_used: expected %0d, got %0d", want.queue_used, got.queue_used);
               error_count++;
            end
            if (got.task_out !== want.task_out) begin
               $error("task_out: expected %h, got %h", want.task_out, got.task_out);
               error_count++;
            end
            if (got.was_stolen !== want.was_stolen) begin
               $error("was_stolen: expected %0d, got %0d", want.was_stolen, got.was_stolen);
               error_count++;
            end
            if (got.active_count !== want.active_count) begin
               $error("active_count: expected %0d, got %0d", want.active_count,
                      got.active_count);
               error_count++;
            end
         end
      end
   end

   task automatic test_basic_ops();
      set_workers(5'd4);
      send_word(OP_SUBMIT, 4'd0, 16'h0000);
      send_word(OP_SUBMIT, 4'd15, 16'hFFFF);
      send_word(OP_SUBMIT, 4'd5, 16'hA5A5);
      send_word(OP_SUBMIT, 4'd10, 16'h5A5A);
      send_word(OP_FETCH, 4'd0, 16'h0000);
      send_word(OP_FETCH, 4'd0, 16'hFFFF);
      send_word(OP_FETCH, 4'd3, 16'h0000);
      send_word(OP_FETCH, 4'd3, 16'h0000);
      send_word(OP_FETCH, 4'd2, 16'h0000);
      send_word(OP_FETCH, 4'd15, 16'hFFFF);
      repeat (5) send_word(OP_COMPLETE, 4'd10, 16'h5A5A);
      send_word(OP_UNUSED, 4'd10, 16'hFFFF);
   endtask

   task automatic test_register_range();
      // zero acts as one queue, above max acts as max
      set_workers(5'd0);
      send_word(OP_SUBMIT, 4'd0, 16'h00FF);
      send_word(OP_FETCH, 4'd1, 16'h0000);
      send_word(OP_FETCH, 4'd0, 16'h0000);
      set_workers(5'd31);
      repeat (4) send_word(OP_SUBMIT, rand_worker(), rand_task());
      // lowered count hides the upper queues
      set_workers(5'd2);
      send_word(OP_FETCH, 4'd1, 16'h0000);
      send_word(OP_FETCH, 4'd1, 16'h0000);
      set_workers(5'd16);
      send_word(OP_FETCH, 4'd12, 16'h0000);
   endtask

   task automatic test_count_saturation();
      set_workers(5'd16);
      rsp_hold_req = 400;
      repeat (1015) send_word(OP_SUBMIT, rand_worker(), rand_task());
      repeat (24) begin
         send_word(OP_FETCH, rand_worker(), rand_task());
         send_word(OP_SUBMIT, rand_worker(), rand_task());
      end
   endtask

   task automatic test_random_mix();
      logic [WCOUNT_W-1:0] wc;
      logic [OP_W-1:0] op;
      logic [WORKER_W-1:0] wkr;
      int pick;
      int n;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: wc = 5'd16;
            1: wc = 5'd1;
            2: wc = 5'd31;
            3: wc = 5'd0;
            4: wc = WCOUNT_W'($urandom_range(2, 15));
            5: wc = 5'd16;
            default: wc = WCOUNT_W'($urandom_range(0, 31));
         endcase
         set_workers(wc);
         n = active_queues(wc);
         req_idle_on = (phase != 0 && phase != 5);
         rsp_idle_on = (phase != 0 && phase != 6);
         repeat (80) begin
            pick = $urandom_range(0, 99);
            if (pick < 42) op = OP_SUBMIT;
            else if (pick < 85) op = OP_FETCH;
            else if (pick < 98) op = OP_COMPLETE;
            else op = OP_UNUSED;
            if ($urandom_range(0, 9) == 0) wkr = rand_worker();
            else wkr = WORKER_W'($urandom_range(0, n - 1));
            send_word(op, wkr, rand_task());
         end
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_SUBMIT;
      csr_we     <= 1'b0;
      csr_wdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_basic_ops();
      test_register_range();
      test_count_saturation();
      test_random_mix();
      wait_idle();
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
